// ----- rtl/assert_macros.svh -----
// assertion macros used by ber_tlv_tag_search
// expects clk and rst_n in scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/btts_pkg.sv -----
// types and constants for the ber-tlv tag search block
// no dependencies; used by every rtl module of the block
package btts_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_TAG_FIRST = 3'd0,
    PH_TAG_MORE  = 3'd1,
    PH_LEN_FIRST = 3'd2,
    PH_LEN_EXT1  = 3'd3,
    PH_LEN_HIGH  = 3'd4,
    PH_LEN_LOW   = 3'd5,
    PH_VALUE     = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  // configuration register indexes
  localparam logic CFG_SEARCH_TAG = 1'b0;
  localparam logic CFG_MAX_COPY   = 1'b1;

  localparam logic [31:0] SEARCH_TAG_RST = 32'h0000_0000;
  localparam logic [15:0] MAX_COPY_RST   = 16'h00FF;

  // ber-tlv codes
  localparam logic [4:0] TAG_MULTI_MARK = 5'h1F;
  localparam logic [7:0] LEN_ONE_EXT    = 8'h81;
  localparam logic [7:0] LEN_TWO_EXT    = 8'h82;

  // output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // one result beat
  typedef struct packed {
    logic [7:0]  value_out;
    logic        is_done;
    logic        found;
    logic [15:0] copied_count;
    logic        last_of_run;
  } res_t;

  // results produced by one accepted input beat
  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// ----- rtl/ber_tlv_tag_search.sv -----
// BER-TLV tag search. One input beat is taken per clock while in_tready is high; each beat
// yields zero, one or two result beats through a four-entry result queue.
// in_tready is high while at least two queue entries are free, so with the output side
// always ready the block sustains one input beat per cycle; only a stalled output or a run
// of two-result beats (value byte plus done) holds the input back. The user must write
// registers on the cfg port only while the block is idle; the block itself does not enforce it.
// depends on btts_pkg, btts_parser, btts_outq and assert_macros.svh
`include "assert_macros.svh"
module ber_tlv_tag_search import btts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] value_out, [8] found, [24:9] copied_count
  output logic        out_tuser,  // is_done
  output logic        out_tlast   // last_of_run
);

  logic [31:0]    search_tag_r;
  logic [15:0]    max_copy_r;
  logic           in_fire;
  logic           out_fire;
  push_t          push;
  res_t           head;
  logic           not_empty;
  logic           room2;
  logic [OQ_AW:0] level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_tag_r <= SEARCH_TAG_RST;
      max_copy_r   <= MAX_COPY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEARCH_TAG: search_tag_r <= cfg_wdata;
        CFG_MAX_COPY:   max_copy_r   <= cfg_wdata[15:0];
        default:        ;
      endcase
    end
  end

  // handshakes
  assign in_tready = room2;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;

  btts_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_fire  (in_fire),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .search_tag (search_tag_r),
    .max_copy   (max_copy_r),
    .push       (push)
  );

  btts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_fire),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2),
    .level     (level)
  );

  // result beat packing
  assign out_tvalid = not_empty;
  assign out_tdata  = {7'd0, head.copied_count, head.found, head.value_out};
  assign out_tuser  = head.is_done;
  assign out_tlast  = head.last_of_run;

  // checks
  `ASSERT_ALWAYS(a_level_bound, level <= (OQ_AW+1)'(OQ_DEPTH), "result queue overfilled")
  `ASSERT_IMPLIES(a_push_needs_beat, push.num != 2'd0, in_fire, "result without input beat")
  `ASSERT_IMPLIES(a_notfound_zero, out_tvalid && out_tuser && !out_tdata[8],
                  out_tdata[24:9] == 16'd0, "not-found done carries a count")

endmodule

// ----- rtl/btts_parser.sv -----
// per-byte tlv parser: phase, tag and length state, result generation
// depends on btts_pkg
module btts_parser import btts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_fire,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] search_tag,
  input  logic [15:0] max_copy,
  output push_t       push
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [15:0] elen_r, elen_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] copied_r, copied_nxt;
  logic        match_r, match_nxt;
  logic        fin_r, fin_nxt;

  logic [15:0] left_dec;
  logic        len_done;
  logic [15:0] len_val;
  logic        byte_v;
  logic        mdone;
  logic        eos;

  // copied count after this byte, before any end-of-buffer clear
  function automatic logic [15:0] copied_nxt_done(input logic        ld,
                                                  input logic        bv,
                                                  input logic [15:0] cr);
    return ld ? 16'd0 : (bv ? cr + 16'd1 : cr);
  endfunction

  assign left_dec = left_r - 16'd1;

  // next state for one byte
  always_comb begin
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    elen_nxt   = elen_r;
    left_nxt   = left_r;
    copied_nxt = copied_r;
    match_nxt  = match_r;
    fin_nxt    = fin_r;
    len_done   = 1'b0;
    len_val    = '0;
    byte_v     = 1'b0;
    mdone      = 1'b0;
    eos        = 1'b0;

    unique case (phase_r)
      PH_TAG_FIRST: begin
        tag_nxt   = {24'd0, data_byte};
        phase_nxt = (data_byte[4:0] == TAG_MULTI_MARK) ? PH_TAG_MORE : PH_LEN_FIRST;
      end
      PH_TAG_MORE: begin
        tag_nxt = {tag_r[23:0], data_byte};
        if (!data_byte[7]) phase_nxt = PH_LEN_FIRST;
      end
      PH_LEN_FIRST: begin
        priority if (data_byte == LEN_ONE_EXT) begin
          phase_nxt = PH_LEN_EXT1;
        end else if (data_byte == LEN_TWO_EXT) begin
          phase_nxt = PH_LEN_HIGH;
        end else begin
          len_done = 1'b1;
          len_val  = {8'd0, data_byte};
        end
      end
      PH_LEN_EXT1: begin
        len_done = 1'b1;
        len_val  = {8'd0, data_byte};
      end
      PH_LEN_HIGH: begin
        elen_nxt  = {data_byte, 8'd0};
        phase_nxt = PH_LEN_LOW;
      end
      PH_LEN_LOW: begin
        len_done = 1'b1;
        len_val  = {elen_r[15:8], data_byte};
      end
      PH_VALUE: begin
        left_nxt = left_dec;
        if (match_r && (copied_r < max_copy)) begin
          byte_v     = 1'b1;
          copied_nxt = copied_r + 16'd1;
        end
        if (left_dec == 16'd0) begin
          if (match_r) begin
            mdone     = 1'b1;
            fin_nxt   = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_TAG_FIRST;
          end
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_TAG_FIRST;
      end
    endcase

    // length complete: compare tag, then start the value; an empty one finishes on a match, else the next tag follows
    if (len_done) begin
      elen_nxt   = len_val;
      left_nxt   = len_val;
      copied_nxt = '0;
      match_nxt  = (tag_r == search_tag);
      if (len_val != 16'd0) begin
        phase_nxt = PH_VALUE;
      end else if (tag_r == search_tag) begin
        mdone     = 1'b1;
        fin_nxt   = 1'b1;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_TAG_FIRST;
      end
    end

    // end of buffer: report not found if still searching, then re-arm
    if (last_byte) begin
      eos        = !fin_nxt;
      phase_nxt  = PH_TAG_FIRST;
      tag_nxt    = '0;
      elen_nxt   = '0;
      left_nxt   = '0;
      copied_nxt = '0;
      match_nxt  = 1'b0;
      fin_nxt    = 1'b0;
    end
  end

  // assemble up to two results in order
  always_comb begin
    res_t bres;
    res_t dres;
    bres              = '0;
    bres.value_out    = data_byte;
    dres              = '0;
    dres.is_done      = 1'b1;
    dres.found        = mdone;
    dres.copied_count = mdone ? copied_nxt_done(len_done, byte_v, copied_r) : 16'd0;

    push = '0;
    if (beat_fire) begin
      push.num = {1'b0, byte_v} + {1'b0, (mdone | eos)};
      if (byte_v) begin
        push.first  = bres;
        push.second = dres;
      end else begin
        push.first = dres;
      end
      if (push.num == 2'd1) push.first.last_of_run = 1'b1;
      if (push.num == 2'd2) push.second.last_of_run = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG_FIRST;
      tag_r    <= '0;
      elen_r   <= '0;
      left_r   <= '0;
      copied_r <= '0;
      match_r  <= 1'b0;
      fin_r    <= 1'b0;
    end else if (beat_fire) begin
      phase_r  <= phase_nxt;
      tag_r    <= tag_nxt;
      elen_r   <= elen_nxt;
      left_r   <= left_nxt;
      copied_r <= copied_nxt;
      match_r  <= match_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

// ----- rtl/btts_outq.sv -----
// result queue: takes up to two results a cycle, gives one a cycle while popped
// depends on btts_pkg
module btts_outq import btts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  push_t            push,
  input  logic             pop,
  output res_t             head,
  output logic             not_empty,
  output logic             room2,
  output logic [OQ_AW:0]   level
);

  res_t              mem [OQ_DEPTH];
  logic [OQ_AW-1:0]  wr_r, wr_nxt;
  logic [OQ_AW-1:0]  rd_r, rd_nxt;
  logic [OQ_AW:0]    cnt_r, cnt_nxt;
  logic [OQ_AW-1:0]  wr_one;

  assign wr_one    = wr_r + 1'b1;
  assign head      = mem[rd_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign level     = cnt_r;

  // pointer and fill updates
  always_comb begin
    wr_nxt  = wr_r + OQ_AW'(push.num);
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (OQ_AW+1)'(push.num) - (OQ_AW+1)'(pop);
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) mem[wr_r]   <= push.first;
    if (push.num == 2'd2) mem[wr_one] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
